>>> rtl/core/gofc_pkg.sv
// Shared types, constants and helpers for the overlap filter and component block.
// No dependencies; used by every module under rtl/core.
`timescale 1ns / 1ps
`default_nettype none

package gofc_pkg;

    localparam int MAX_V    = 64;
    localparam int V_W      = $clog2(MAX_V);
    localparam int N_W      = V_W + 1;
    localparam int MAX_E    = 256;
    localparam int E_W      = $clog2(MAX_E);
    localparam int EH_W     = E_W + 1;
    localparam int CNT_W    = 8;
    localparam int ROW_W    = MAX_V * CNT_W;
    localparam int OVL_W    = 14;
    localparam int CUT_W    = 15;
    localparam int WGT_W    = 32;
    localparam int LBL_W    = 6;
    localparam int TOT_W    = 7;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [OVL_W-1:0] OVL_MAX = '1;

    // Function codes on the input word.
    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_QEDGE = 2'd1;
    localparam logic [1:0] FUNC_QVERT = 2'd2;

    // Status codes on the result word.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    // Configuration register indexes.
    localparam logic REG_VERTEX_COUNT = 1'b0;
    localparam logic REG_CUTOFF       = 1'b1;

    localparam logic [N_W-1:0] VC_RESET = N_W'(MAX_V);

    typedef enum logic [2:0] {
        OP_ADD       = 3'd0,
        OP_QEDGE     = 3'd1,
        OP_QVERT     = 3'd2,
        OP_ERR_FULL  = 3'd3,
        OP_ERR_RANGE = 3'd4
    } op_t;

    // Classified command handed from the front to the back.
    typedef struct packed {
        op_t              op;
        logic [V_W-1:0]   va;
        logic [V_W-1:0]   vb;
        logic [WGT_W-1:0] weight;
        logic [E_W-1:0]   idx;
    } cmd_t;

    typedef struct packed {
        logic [1:0]       status;
        logic             kept;
        logic [V_W-1:0]   edge_first;
        logic [V_W-1:0]   edge_second;
        logic [WGT_W-1:0] edge_weight;
        logic [OVL_W-1:0] overlap_count;
        logic [LBL_W-1:0] component_id;
        logic [TOT_W-1:0] component_total;
    } result_t;

    typedef struct packed {
        logic [N_W-1:0]   n;
        logic [CUT_W-1:0] cutoff;
        logic             inval;
    } cfg_t;

    // Clamp the vertex count register to the usable range.
    function automatic logic [N_W-1:0] used_n(input logic [N_W-1:0] vc);
        logic [N_W-1:0] r;
        if (vc == '0)
            r = N_W'(1);
        else if (vc > N_W'(MAX_V))
            r = N_W'(MAX_V);
        else
            r = vc;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/gofc_front.sv
// Front end: accepts input words, classifies them and queues commands.
// Depends on gofc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gofc_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [1:0]                    func,
    input  wire logic [gofc_pkg::V_W-1:0]      vertex_a,
    input  wire logic [gofc_pkg::V_W-1:0]      vertex_b,
    input  wire logic [gofc_pkg::WGT_W-1:0]    weight,
    input  wire logic [gofc_pkg::E_W-1:0]      edge_index,
    input  wire logic [gofc_pkg::N_W-1:0]      n,
    output logic                               head_valid,
    output gofc_pkg::cmd_t                     head,
    input  wire logic                          head_pop
);
    import gofc_pkg::*;

    cmd_t            q_reg [2];
    logic            wp_reg, wp_next;
    logic            rp_reg, rp_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic [EH_W-1:0] held_reg, held_next;
    logic            acc;
    cmd_t            cls;

    assign full       = (cnt_reg == 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = q_reg[rp_reg];
    assign acc        = push && !full;

    // Classify the incoming word; the front owns the stored edge count.
    always_comb
    begin
        cls.va     = vertex_a;
        cls.vb     = vertex_b;
        cls.weight = weight;
        cls.idx    = edge_index;
        held_next  = held_reg;
        cls.op     = OP_ERR_RANGE;
        unique case (func)
            FUNC_ADD:
            begin
                if ({1'b0, vertex_a} >= n || {1'b0, vertex_b} >= n)
                    cls.op = OP_ERR_RANGE;
                else if (held_reg >= EH_W'(MAX_E))
                    cls.op = OP_ERR_FULL;
                else
                begin
                    cls.op  = OP_ADD;
                    cls.idx = held_reg[E_W-1:0];
                    if (acc)
                        held_next = held_reg + EH_W'(1);
                end
            end
            FUNC_QEDGE:
            begin
                if ({1'b0, edge_index} >= held_reg)
                    cls.op = OP_ERR_RANGE;
                else
                    cls.op = OP_QEDGE;
            end
            FUNC_QVERT:
            begin
                if ({1'b0, vertex_a} >= n)
                    cls.op = OP_ERR_RANGE;
                else
                    cls.op = OP_QVERT;
            end
            default:
                cls.op = OP_ERR_RANGE;
        endcase
    end

    // Queue pointers.
    always_comb
    begin
        wp_next  = acc ? ~wp_reg : wp_reg;
        rp_next  = head_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, acc} - {1'b0, head_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
            cnt_reg  <= 2'd0;
            held_reg <= '0;
        end
        else
        begin
            wp_reg   <= wp_next;
            rp_reg   <= rp_next;
            cnt_reg  <= cnt_next;
            held_reg <= held_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (acc)
            q_reg[wp_reg] <= cls;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'd2)
        else $error("command queue count out of range");
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= EH_W'(MAX_E))
        else $error("edge count beyond table size");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        head_pop |-> head_valid)
        else $error("pop from empty command queue");

endmodule

`default_nettype wire

>>> rtl/core/gofc_back.sv
// Back end: executes commands against the matrix, edge list and labels.
// Depends on gofc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gofc_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire gofc_pkg::cfg_t cfg,
    input  wire logic           head_valid,
    input  wire gofc_pkg::cmd_t head,
    output logic                head_pop,
    output logic                res_valid,
    output gofc_pkg::result_t   res,
    input  wire logic           res_pop
);
    import gofc_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE    = 14'b00000000000001,
        S_ADD_RD  = 14'b00000000000010,
        S_ADD_WRA = 14'b00000000000100,
        S_ADD_WRB = 14'b00000000001000,
        S_QE_RD   = 14'b00000000010000,
        S_QE_ROW  = 14'b00000000100000,
        S_QE_SUM  = 14'b00000001000000,
        S_QE_OUT  = 14'b00000010000000,
        S_RL_INIT = 14'b00000100000000,
        S_RL_SEED = 14'b00001000000000,
        S_RL_POP  = 14'b00010000000000,
        S_RL_EXP  = 14'b00100000000000,
        S_LB_RD   = 14'b01000000000000,
        S_LB_OUT  = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    // Memories.
    logic [ROW_W-1:0] mat_mem [MAX_V];
    logic [V_W+V_W+WGT_W-1:0] edge_mem [MAX_E];
    logic [LBL_W-1:0] lbl_mem [MAX_V];
    logic [MAX_V-1:0] rv_reg, rv_next;

    logic             mat_we;
    logic [V_W-1:0]   mat_wa, ra, rb;
    logic [ROW_W-1:0] mat_wd;
    logic [ROW_W-1:0] rowa_reg, rowb_reg, rowa_m, rowb_m;
    logic             rowa_v_reg, rowb_v_reg;
    logic             edge_we;
    logic [V_W+V_W+WGT_W-1:0] edge_q_reg;
    logic             lbl_we;
    logic [V_W-1:0]   lbl_wa;
    logic [LBL_W-1:0] lbl_q_reg;

    cmd_t             cur_reg, cur_next;
    logic [N_W-1:0]   x_reg, x_next;
    logic [OVL_W-1:0] sum_reg, sum_next;
    logic             lv_reg, lv_next;
    logic [TOT_W-1:0] found_reg, found_next;
    logic [TOT_W-1:0] comps_reg, comps_next;
    logic [N_W-1:0]   i_reg, i_next;
    logic [MAX_V-1:0] vis_reg, vis_next;
    logic [MAX_V-1:0] pend_reg, pend_next;
    logic             rv_valid_reg, rv_valid_next;
    result_t          res_reg, res_next;

    logic [V_W-1:0]   low_idx;
    logic [MAX_V-1:0] adj, fresh;
    logic [CNT_W-1:0] ea, eb, emin;
    logic [OVL_W:0]   sum_w;
    logic [V_W-1:0]   e_first, e_second;
    logic [WGT_W-1:0] e_weight;

    // Lowest pending vertex.
    function automatic logic [V_W-1:0] lowest(input logic [MAX_V-1:0] p);
        logic [V_W-1:0] r;
        r = '0;
        for (int k = MAX_V - 1; k >= 0; k--)
            if (p[k])
                r = V_W'(k);
        return r;
    endfunction

    // Saturating increment of one entry; a self loop adds two.
    function automatic logic [ROW_W-1:0] bump_row(input logic [ROW_W-1:0] row,
                                                  input logic [V_W-1:0] col,
                                                  input logic two);
        logic [ROW_W-1:0] r;
        logic [CNT_W-1:0] e;
        r = row;
        e = row[col*CNT_W +: CNT_W];
        if (two)
            e = (e >= CNT_MAX - CNT_W'(1)) ? CNT_MAX : e + CNT_W'(2);
        else
            e = (e == CNT_MAX) ? CNT_MAX : e + CNT_W'(1);
        r[col*CNT_W +: CNT_W] = e;
        return r;
    endfunction

    assign rowa_m   = rowa_v_reg ? rowa_reg : '0;
    assign rowb_m   = rowb_v_reg ? rowb_reg : '0;
    assign e_first  = edge_q_reg[V_W+V_W+WGT_W-1 -: V_W];
    assign e_second = edge_q_reg[V_W+WGT_W-1 -: V_W];
    assign e_weight = edge_q_reg[WGT_W-1:0];
    assign low_idx  = lowest(pend_reg);

    // Overlap term for the current column.
    always_comb
    begin
        ea    = rowa_m[x_reg[V_W-1:0]*CNT_W +: CNT_W];
        eb    = rowb_m[x_reg[V_W-1:0]*CNT_W +: CNT_W];
        emin  = (ea < eb) ? ea : eb;
        sum_w = {1'b0, sum_reg} + (OVL_W+1)'(emin);
    end

    // Neighbors of the row being expanded, limited to vertices in use.
    always_comb
    begin
        for (int j = 0; j < MAX_V; j++)
            adj[j] = (rowa_m[j*CNT_W +: CNT_W] != '0) && (N_W'(j) < cfg.n);
        fresh = adj & ~vis_reg;
    end

    assign res_valid = rv_valid_reg;
    assign res       = res_reg;

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        x_next        = x_reg;
        sum_next      = sum_reg;
        lv_next       = lv_reg;
        found_next    = found_reg;
        comps_next    = comps_reg;
        i_next        = i_reg;
        vis_next      = vis_reg;
        pend_next     = pend_reg;
        rv_next       = rv_reg;
        rv_valid_next = rv_valid_reg && !res_pop;
        res_next      = res_reg;
        head_pop      = 1'b0;
        mat_we        = 1'b0;
        mat_wa        = cur_reg.va;
        mat_wd        = '0;
        ra            = cur_reg.va;
        rb            = cur_reg.vb;
        edge_we       = 1'b0;
        lbl_we        = 1'b0;
        lbl_wa        = low_idx;

        unique case (state_reg)
            S_IDLE:
            begin
                if (head_valid && (!rv_valid_reg || res_pop))
                begin
                    head_pop = 1'b1;
                    cur_next = head;
                    unique case (head.op)
                        OP_ADD:
                            state_next = S_ADD_RD;
                        OP_QEDGE:
                            state_next = S_QE_RD;
                        OP_QVERT:
                            state_next = lv_reg ? S_LB_RD : S_RL_INIT;
                        OP_ERR_FULL:
                        begin
                            res_next        = '0;
                            res_next.status = STAT_FULL;
                            rv_valid_next   = 1'b1;
                        end
                        default:
                        begin
                            res_next        = '0;
                            res_next.status = STAT_RANGE;
                            rv_valid_next   = 1'b1;
                        end
                    endcase
                end
            end
            S_ADD_RD:
            begin
                edge_we    = 1'b1;
                state_next = S_ADD_WRA;
            end
            S_ADD_WRA:
            begin
                mat_we     = 1'b1;
                mat_wa     = cur_reg.va;
                mat_wd     = bump_row(rowa_m, cur_reg.vb, cur_reg.va == cur_reg.vb);
                rv_next[cur_reg.va] = 1'b1;
                lv_next    = 1'b0;
                if (cur_reg.va == cur_reg.vb)
                begin
                    res_next      = '0;
                    rv_valid_next = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                    state_next = S_ADD_WRB;
            end
            S_ADD_WRB:
            begin
                mat_we        = 1'b1;
                mat_wa        = cur_reg.vb;
                mat_wd        = bump_row(rowb_m, cur_reg.va, 1'b0);
                rv_next[cur_reg.vb] = 1'b1;
                res_next      = '0;
                rv_valid_next = 1'b1;
                state_next    = S_IDLE;
            end
            S_QE_RD:
                state_next = S_QE_ROW;
            S_QE_ROW:
            begin
                ra         = e_first;
                rb         = e_second;
                x_next     = '0;
                sum_next   = '0;
                state_next = S_QE_SUM;
            end
            S_QE_SUM:
            begin
                // Keep both endpoint rows on the read ports while summing.
                ra = e_first;
                rb = e_second;
                if (x_reg >= cfg.n)
                    state_next = S_QE_OUT;
                else
                begin
                    sum_next = (sum_w > (OVL_W+1)'(OVL_MAX)) ? OVL_MAX : sum_w[OVL_W-1:0];
                    x_next   = x_reg + N_W'(1);
                end
            end
            S_QE_OUT:
            begin
                res_next               = '0;
                res_next.kept          = $signed({1'b0, sum_reg}) > $signed(cfg.cutoff);
                res_next.edge_first    = e_first;
                res_next.edge_second   = e_second;
                res_next.edge_weight   = e_weight;
                res_next.overlap_count = sum_reg;
                rv_valid_next          = 1'b1;
                state_next             = S_IDLE;
            end
            S_RL_INIT:
            begin
                vis_next   = '0;
                pend_next  = '0;
                i_next     = '0;
                comps_next = '0;
                state_next = S_RL_SEED;
            end
            S_RL_SEED:
            begin
                if (i_reg >= cfg.n)
                begin
                    lv_next    = 1'b1;
                    found_next = comps_reg;
                    state_next = S_LB_RD;
                end
                else if (vis_reg[i_reg[V_W-1:0]])
                    i_next = i_reg + N_W'(1);
                else
                begin
                    vis_next[i_reg[V_W-1:0]]  = 1'b1;
                    pend_next[i_reg[V_W-1:0]] = 1'b1;
                    state_next = S_RL_POP;
                end
            end
            S_RL_POP:
            begin
                if (pend_reg == '0)
                begin
                    comps_next = comps_reg + TOT_W'(1);
                    i_next     = i_reg + N_W'(1);
                    state_next = S_RL_SEED;
                end
                else
                begin
                    pend_next[low_idx] = 1'b0;
                    lbl_we     = 1'b1;
                    ra         = low_idx;
                    state_next = S_RL_EXP;
                end
            end
            S_RL_EXP:
            begin
                vis_next   = vis_reg | fresh;
                pend_next  = pend_reg | fresh;
                state_next = S_RL_POP;
            end
            S_LB_RD:
                state_next = S_LB_OUT;
            S_LB_OUT:
            begin
                res_next                 = '0;
                res_next.component_id    = lbl_q_reg;
                res_next.component_total = found_reg;
                rv_valid_next            = 1'b1;
                state_next               = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase

        if (cfg.inval)
            lv_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            lv_reg       <= 1'b0;
            found_reg    <= '0;
            comps_reg    <= '0;
            i_reg        <= '0;
            vis_reg      <= '0;
            pend_reg     <= '0;
            rv_reg       <= '0;
            rv_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            lv_reg       <= lv_next;
            found_reg    <= found_next;
            comps_reg    <= comps_next;
            i_reg        <= i_next;
            vis_reg      <= vis_next;
            pend_reg     <= pend_next;
            rv_reg       <= rv_next;
            rv_valid_reg <= rv_valid_next;
        end
    end

    // Working registers without reset.
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        x_reg   <= x_next;
        sum_reg <= sum_next;
        res_reg <= res_next;
    end

    // Matrix rows with two registered read ports; row valid bits stand for a cleared row.
    always_ff @(posedge clk)
    begin
        if (mat_we)
            mat_mem[mat_wa] <= mat_wd;
        rowa_reg   <= mat_mem[ra];
        rowb_reg   <= mat_mem[rb];
        rowa_v_reg <= rv_reg[ra];
        rowb_v_reg <= rv_reg[rb];
    end

    // Edge list.
    always_ff @(posedge clk)
    begin
        if (edge_we)
            edge_mem[cur_reg.idx] <= {cur_reg.va, cur_reg.vb, cur_reg.weight};
        edge_q_reg <= edge_mem[cur_reg.idx];
    end

    // Component labels.
    always_ff @(posedge clk)
    begin
        if (lbl_we)
            lbl_mem[lbl_wa] <= comps_reg[LBL_W-1:0];
        lbl_q_reg <= lbl_mem[cur_reg.va];
    end

    a_pop_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        head_pop |-> (!rv_valid_reg || res_pop))
        else $error("command taken while result slot is occupied");
    a_relabel_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RL_SEED && i_reg >= cfg.n && !cfg.inval) |=> lv_reg)
        else $error("labels not marked current after walk");
    a_add_clears_labels: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADD_WRA) |=> !lv_reg)
        else $error("labels still current after an edge was added");
    a_err_status: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && head_pop && head.op == OP_ERR_RANGE)
        |=> (rv_valid_reg && res_reg.status == STAT_RANGE))
        else $error("range error word not reported");

endmodule

`default_nettype wire

>>> rtl/core/graph_overlap_filter_and_components_top.sv
// Top level of the overlap filter and component block: configuration
// registers, front end and back end. Depends on gofc_pkg, gofc_front, gofc_back.
`timescale 1ns / 1ps
`default_nettype none

// Words enter through a two-entry command queue and are executed one at a
// time by the back end, which holds the result in an output register. An add
// writes the edge list, then row a, then row b (skipped for a self loop); an
// edge query reads the edge, then both endpoint rows, and sums one column per
// vertex in use. A vertex query reads the label when the labels are current.
// After an add or a vertex count write the next vertex query first relabels
// by a walk over the vertices in use. Error words are answered from idle.
// The matrix needs no clearing pass after reset; each row carries a valid bit.
module graph_overlap_filter_and_components_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic                          cfg_index,
    input  wire logic [gofc_pkg::CUT_W-1:0]    cfg_data,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [1:0]                    func,
    input  wire logic [gofc_pkg::V_W-1:0]      vertex_a,
    input  wire logic [gofc_pkg::V_W-1:0]      vertex_b,
    input  wire logic [gofc_pkg::WGT_W-1:0]    weight,
    input  wire logic [gofc_pkg::E_W-1:0]      edge_index,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [1:0]                         status,
    output logic                               kept,
    output logic [gofc_pkg::V_W-1:0]           edge_first,
    output logic [gofc_pkg::V_W-1:0]           edge_second,
    output logic [gofc_pkg::WGT_W-1:0]         edge_weight,
    output logic [gofc_pkg::OVL_W-1:0]         overlap_count,
    output logic [gofc_pkg::LBL_W-1:0]         component_id,
    output logic [gofc_pkg::TOT_W-1:0]         component_total
);
    import gofc_pkg::*;

    logic [N_W-1:0]   vc_reg;
    logic [CUT_W-1:0] cutoff_reg;
    cfg_t             cfg;
    logic             head_valid, head_pop, res_valid;
    cmd_t             head;
    result_t          res;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg     <= VC_RESET;
            cutoff_reg <= '0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_VERTEX_COUNT)
                vc_reg <= cfg_data[N_W-1:0];
            else
                cutoff_reg <= cfg_data;
        end
    end

    assign cfg.n      = used_n(vc_reg);
    assign cfg.cutoff = cutoff_reg;
    assign cfg.inval  = cfg_write && (cfg_index == REG_VERTEX_COUNT);

    gofc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .func       (func),
        .vertex_a   (vertex_a),
        .vertex_b   (vertex_b),
        .weight     (weight),
        .edge_index (edge_index),
        .n          (cfg.n),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop)
    );

    gofc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop),
        .res_valid  (res_valid),
        .res        (res),
        .res_pop    (pop)
    );

    // Result word.
    assign empty           = !res_valid;
    assign status          = res.status;
    assign kept            = res.kept;
    assign edge_first      = res.edge_first;
    assign edge_second     = res.edge_second;
    assign edge_weight     = res.edge_weight;
    assign overlap_count   = res.overlap_count;
    assign component_id    = res.component_id;
    assign component_total = res.component_total;

endmodule

`default_nettype wire
